// ===== rtl/core/stereo_sustain_compressor_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sustain compressor
// Shared macros for the port-level checks of the compressor top level.
// ----------------------------------------------------------------------------
`ifndef STEREO_SUSTAIN_COMPRESSOR_TOP_ASSERT_SVH
`define STEREO_SUSTAIN_COMPRESSOR_TOP_ASSERT_SVH

// Checks that only hold outside reset.
`define SSC_ASSERT_ON(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Checks that also look at the reset itself.
`define SSC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) \
        else $error(msg);

`endif

// ===== rtl/core/ssc_pkg.sv =====
// ----------------------------------------------------------------------------
// ssc_pkg
// Widths, reset values, register indexes and shared types of the compressor.
// ----------------------------------------------------------------------------
package ssc_pkg;

    localparam int LEVEL_W    = 32;
    localparam int COEF_W     = 17;
    localparam int GAIN_W     = 24;
    localparam int THR_W      = 31;
    localparam int HOLD_W     = 16;
    localparam int TIMER_W    = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;
    localparam int DIVD_W     = 64;
    localparam int MUL_B_W    = 25;
    localparam int FRAC_SH    = 16;

    localparam logic [COEF_W-1:0]  UNITY     = 17'h10000;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 32'hFFFF_FFFF;

    // Register reset values.
    localparam logic [GAIN_W-1:0]  RST_INPUT_GAIN   = 24'd375717;
    localparam logic [COEF_W-1:0]  RST_OUTPUT_LEVEL = 17'd32768;
    localparam logic [THR_W-1:0]   RST_BASE_THR     = 31'd2097152;
    localparam logic [COEF_W-1:0]  RST_COMP_RATIO   = 17'd16384;
    localparam logic [COEF_W-1:0]  RST_PEAK_RELEASE = 17'd0;
    localparam logic [COEF_W-1:0]  RST_ENV_ALPHA    = 17'd65536;
    localparam logic [HOLD_W-1:0]  RST_HOLD_SAMPLES = 16'd600;
    localparam logic [LEVEL_W-1:0] RST_DYN_THR      = 32'd2097152;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LEVEL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_THR     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COMP_RATIO   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_RELEASE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ENV_ALPHA    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_SAMPLES = 3'd6;

    // Request to the shared divider.
    typedef struct packed {
        logic                start;
        logic [DIVD_W-1:0]   dividend;
        logic [LEVEL_W-1:0]  divisor;
    } t_div_req;

endpackage

// ===== rtl/core/stereo_sustain_compressor_top.sv =====
// One item is processed at a time: input is accepted only in the idle state,
// and the sequencer runs the gain, peak, envelope and output steps; when the
// envelope is above the threshold it also runs the two divisions.
// A finished result may wait in the output register while the next item runs.
// Reset (synchronous, active low) restores the register defaults, clears peak,
// envelope and hold timer, and sets the threshold to the default base.
// ----------------------------------------------------------------------------
// stereo_sustain_compressor_top
// Peak and envelope driven stereo compressor built around one shared
// multiplier and one shared bit-serial divider under a one-hot sequencer.
// ----------------------------------------------------------------------------
module stereo_sustain_compressor_top #(
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_left_in,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_right_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]      o_left_out,
    output logic signed [SAMPLE_WIDTH-1:0]      o_right_out,
    input  logic                                i_cfg_we,
    input  logic [ssc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [ssc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    import ssc_pkg::*;

    localparam int SW = SAMPLE_WIDTH;
    // Gained samples carry eight more integer bits than the input.
    localparam int GW = SW + 8;
    localparam int MA = (GW > LEVEL_W + 1) ? GW : LEVEL_W + 1;
    localparam int PW = MA + MUL_B_W;

    // The sequencer walks through one step of the shared multiplier per
    // state; each state reads the product issued by the state before it.
    typedef enum logic [19:0] {
        ST_IDLE  = 20'h00001,
        ST_GL    = 20'h00002,
        ST_GR    = 20'h00004,
        ST_PEAK  = 20'h00008,
        ST_REL   = 20'h00010,
        ST_ENV0  = 20'h00020,
        ST_ENV1  = 20'h00040,
        ST_ENV2  = 20'h00080,
        ST_CMP   = 20'h00100,
        ST_LV1   = 20'h00200,
        ST_LV2   = 20'h00400,
        ST_DIV1  = 20'h00800,
        ST_NT    = 20'h01000,
        ST_DIV2  = 20'h02000,
        ST_CLAMP = 20'h04000,
        ST_TL    = 20'h08000,
        ST_TR    = 20'h10000,
        ST_OL    = 20'h20000,
        ST_OR    = 20'h40000,
        ST_DONE  = 20'h80000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers.
    logic [GAIN_W-1:0]  r_input_gain;
    logic [COEF_W-1:0]  r_output_level;
    logic [THR_W-1:0]   r_base_thr;
    logic [COEF_W-1:0]  r_comp_ratio;
    logic [COEF_W-1:0]  r_peak_release;
    logic [COEF_W-1:0]  r_env_alpha;
    logic [HOLD_W-1:0]  r_hold_samples;

    // Detector state.
    logic [LEVEL_W-1:0] r_peak;
    logic [LEVEL_W-1:0] r_env;
    logic [LEVEL_W-1:0] r_thr;
    logic [TIMER_W-1:0] r_timer;
    logic               r_decay;

    // Per-item working registers.
    logic signed [SW-1:0] r_left, r_right;
    logic signed [GW-1:0] r_gl, r_gr, r_tl, r_tr;
    logic [DIVD_W-1:0]    r_acc;
    logic [LEVEL_W-1:0]   r_lvl;
    logic [LEVEL_W-1:0]   r_nt;
    logic [COEF_W-1:0]    r_gain;
    logic [SW-1:0]        r_res_l, r_res_r;

    // Output register.
    logic                 r_out_valid;
    logic [SW-1:0]        r_out_l, r_out_r;

    // Shared units.
    logic signed [MA-1:0]      w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic signed [PW-1:0]      w_prod;
    logic signed [PW-1:0]      w_psh;
    t_div_req                  w_div_req;
    logic                      w_div_done;
    logic [LEVEL_W-1:0]        w_quot;

    // Datapath helpers.
    logic signed [GW:0]   w_sum;
    logic signed [GW-1:0] w_mean;
    logic [GW-1:0]        w_abs;
    logic [DIVD_W-1:0]    w_abs64;
    logic [LEVEL_W-1:0]   w_mag;
    logic                 w_new_pk;
    logic [TIMER_W-1:0]   w_tm;
    logic                 w_decay;
    logic [COEF_W-1:0]    w_alpha;
    logic [COEF_W-1:0]    w_ialpha;
    logic [LEVEL_W-1:0]   w_rel;
    logic [DIVD_W-1:0]    w_env_sum;
    logic [LEVEL_W-1:0]   w_diff;
    logic [LEVEL_W+1:0]   w_nt_sum;
    logic [LEVEL_W-1:0]   w_thr_lo;
    logic [LEVEL_W-1:0]   w_thr_c;
    logic                 w_fit;
    logic [SW-1:0]        w_sat;
    logic                 w_out_free;
    logic                 w_in_xfer;

    ssc_mul #(
        .AW (MA),
        .BW (MUL_B_W)
    ) u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    ssc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_psh      = w_prod >>> FRAC_SH;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_in_xfer  = i_in_valid && (r_state == ST_IDLE);

    // Mono mean of the gained pair; the right product arrives in ST_PEAK.
    assign w_sum   = {r_gl[GW-1], r_gl} + {w_psh[GW-1], w_psh[GW-1:0]};
    assign w_mean  = w_sum[GW:1];
    assign w_abs   = w_mean[GW-1] ? (~w_mean + 1'b1) : w_mean;
    assign w_abs64 = DIVD_W'(w_abs);
    assign w_mag   = (w_abs64 > DIVD_W'(LEVEL_MAX)) ? LEVEL_MAX : w_abs64[LEVEL_W-1:0];

    // A new maximum restarts the hold; decay starts once the timer passes it.
    assign w_new_pk = w_mag > r_peak;
    assign w_tm     = w_new_pk ? '0 : r_timer;
    assign w_decay  = w_tm > {1'b0, r_hold_samples};

    assign w_alpha   = (r_env_alpha > UNITY) ? UNITY : r_env_alpha;
    assign w_ialpha  = UNITY - w_alpha;
    assign w_rel     = (|w_psh[PW-1:LEVEL_W]) ? LEVEL_MAX : w_psh[LEVEL_W-1:0];
    assign w_env_sum = r_acc + DIVD_W'(w_prod);
    assign w_diff    = r_env - r_thr;
    assign w_nt_sum  = (LEVEL_W+2)'(r_base_thr) + {1'b0, w_psh[LEVEL_W:0]};

    // Threshold clamp: never above the envelope, never below the base.
    assign w_thr_lo = (r_env < r_thr) ? r_env : r_thr;
    assign w_thr_c  = (w_thr_lo < LEVEL_W'(r_base_thr)) ? LEVEL_W'(r_base_thr) : w_thr_lo;

    // Saturation of a scaled product to the sample width.
    assign w_fit = (&w_psh[PW-1:SW-1]) | ~(|w_psh[PW-1:SW-1]);
    assign w_sat = w_fit ? w_psh[SW-1:0] :
                   (w_psh[PW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}});

    // Operand selection for the shared multiplier.
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            ST_GL: begin
                w_mul_a = MA'(r_left);
                w_mul_b = MUL_B_W'(r_input_gain);
            end
            ST_GR: begin
                w_mul_a = MA'(r_right);
                w_mul_b = MUL_B_W'(r_input_gain);
            end
            ST_REL: begin
                w_mul_a = MA'(r_peak);
                w_mul_b = MUL_B_W'(r_peak_release);
            end
            ST_ENV0: begin
                w_mul_a = MA'(r_env);
                w_mul_b = MUL_B_W'(w_ialpha);
            end
            ST_ENV1: begin
                w_mul_a = MA'(r_peak);
                w_mul_b = MUL_B_W'(w_alpha);
            end
            ST_CMP: begin
                w_mul_a = MA'(r_thr);
                w_mul_b = MUL_B_W'(w_diff[15:0]);
            end
            ST_LV1: begin
                w_mul_a = MA'(r_thr);
                w_mul_b = MUL_B_W'(w_diff[LEVEL_W-1:16]);
            end
            ST_DIV1: begin
                w_mul_a = MA'(w_quot);
                w_mul_b = MUL_B_W'(r_comp_ratio);
            end
            ST_CLAMP: begin
                w_mul_a = MA'(r_gl);
                w_mul_b = MUL_B_W'(r_gain);
            end
            ST_TL: begin
                w_mul_a = MA'(r_gr);
                w_mul_b = MUL_B_W'(r_gain);
            end
            ST_TR: begin
                w_mul_a = MA'(r_tl);
                w_mul_b = MUL_B_W'(r_output_level);
            end
            ST_OL: begin
                w_mul_a = MA'(r_tr);
                w_mul_b = MUL_B_W'(r_output_level);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // Divider requests: the level quotient, then the gain quotient.
    always_comb begin
        w_div_req.start    = 1'b0;
        w_div_req.dividend = '0;
        w_div_req.divisor  = r_env;
        if (r_state == ST_LV2) begin
            w_div_req.start    = 1'b1;
            w_div_req.dividend = r_acc + (DIVD_W'(w_prod) << FRAC_SH);
        end else if (r_state == ST_NT) begin
            w_div_req.start    = 1'b1;
            w_div_req.dividend = {{(DIVD_W-LEVEL_W-FRAC_SH){1'b0}}, r_lvl, {FRAC_SH{1'b0}}};
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_in_valid) n_state = ST_GL;
            ST_GL:    n_state = ST_GR;
            ST_GR:    n_state = ST_PEAK;
            ST_PEAK:  n_state = ST_REL;
            ST_REL:   n_state = ST_ENV0;
            ST_ENV0:  n_state = ST_ENV1;
            ST_ENV1:  n_state = ST_ENV2;
            ST_ENV2:  n_state = ST_CMP;
            ST_CMP:   n_state = (r_env > r_thr) ? ST_LV1 : ST_CLAMP;
            ST_LV1:   n_state = ST_LV2;
            ST_LV2:   n_state = ST_DIV1;
            ST_DIV1:  if (w_div_done) n_state = ST_NT;
            ST_NT:    n_state = ST_DIV2;
            ST_DIV2:  if (w_div_done) n_state = ST_CLAMP;
            ST_CLAMP: n_state = ST_TL;
            ST_TL:    n_state = ST_TR;
            ST_TR:    n_state = ST_OL;
            ST_OL:    n_state = ST_OR;
            ST_OR:    n_state = ST_DONE;
            ST_DONE:  if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Control state, configuration and detector state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_input_gain   <= RST_INPUT_GAIN;
            r_output_level <= RST_OUTPUT_LEVEL;
            r_base_thr     <= RST_BASE_THR;
            r_comp_ratio   <= RST_COMP_RATIO;
            r_peak_release <= RST_PEAK_RELEASE;
            r_env_alpha    <= RST_ENV_ALPHA;
            r_hold_samples <= RST_HOLD_SAMPLES;
            r_peak         <= '0;
            r_env          <= '0;
            r_thr          <= RST_DYN_THR;
            r_timer        <= '0;
            r_decay        <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_INPUT_GAIN:   r_input_gain   <= i_cfg_data[GAIN_W-1:0];
                    CFG_OUTPUT_LEVEL: r_output_level <= i_cfg_data[COEF_W-1:0];
                    CFG_BASE_THR:     r_base_thr     <= i_cfg_data[THR_W-1:0];
                    CFG_COMP_RATIO:   r_comp_ratio   <= i_cfg_data[COEF_W-1:0];
                    CFG_PEAK_RELEASE: r_peak_release <= i_cfg_data[COEF_W-1:0];
                    CFG_ENV_ALPHA:    r_env_alpha    <= i_cfg_data[COEF_W-1:0];
                    CFG_HOLD_SAMPLES: r_hold_samples <= i_cfg_data[HOLD_W-1:0];
                    default: ;
                endcase
            end

            case (r_state)
                ST_PEAK: begin
                    r_peak  <= w_new_pk ? w_mag : r_peak;
                    r_timer <= w_decay ? w_tm : w_tm + 1'b1;
                    r_decay <= w_decay;
                end
                ST_ENV0: if (r_decay) r_peak <= w_rel;
                ST_ENV2: r_env <= w_env_sum[FRAC_SH+LEVEL_W-1:FRAC_SH];
                ST_DIV2: if (w_div_done) r_thr <= r_nt;
                ST_CLAMP: r_thr <= w_thr_c;
                default: ;
            endcase

            // A new result takes the output register when it is free;
            // otherwise a waiting result leaves on its transfer.
            if (r_state == ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers of the item in flight.
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_left  <= i_left_in;
            r_right <= i_right_in;
        end
        case (r_state)
            ST_GR:   r_gl <= w_psh[GW-1:0];
            ST_PEAK: r_gr <= w_psh[GW-1:0];
            ST_ENV1: r_acc <= DIVD_W'(w_prod);
            ST_CMP:  r_gain <= UNITY;
            ST_LV1:  r_acc <= DIVD_W'(w_prod);
            ST_DIV1: if (w_div_done) r_lvl <= r_thr + w_quot;
            ST_NT:   r_nt <= (|w_nt_sum[LEVEL_W+1:LEVEL_W]) ? LEVEL_MAX : w_nt_sum[LEVEL_W-1:0];
            ST_DIV2: if (w_div_done) r_gain <= w_quot[COEF_W-1:0];
            ST_TL:   r_tl <= w_psh[GW-1:0];
            ST_TR:   r_tr <= w_psh[GW-1:0];
            ST_OL:   r_res_l <= w_sat;
            ST_OR:   r_res_r <= w_sat;
            default: ;
        endcase
        if (r_state == ST_DONE && w_out_free) begin
            r_out_l <= r_res_l;
            r_out_r <= r_res_r;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_left_out  = r_out_l;
    assign o_right_out = r_out_r;

endmodule

// ===== rtl/core/ssc_mul.sv =====
// ----------------------------------------------------------------------------
// ssc_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module ssc_mul #(
    parameter int AW = 33,
    parameter int BW = 25
) (
    input  logic                    i_clk,
    input  logic signed [AW-1:0]    i_a,
    input  logic signed [BW-1:0]    i_b,
    output logic signed [AW+BW-1:0] o_p
);

    logic signed [AW+BW-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// ===== rtl/core/ssc_div.sv =====
// ----------------------------------------------------------------------------
// ssc_div
// Restoring divider, one quotient bit per cycle, 64 by 32 bits.
// ----------------------------------------------------------------------------
module ssc_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ssc_pkg::t_div_req                  i_req,
    output logic                               o_done,
    output logic [ssc_pkg::LEVEL_W-1:0]        o_quot
);

    import ssc_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [4:0]           r_cnt;
    logic [LEVEL_W-1:0]   r_rem;
    logic [LEVEL_W-1:0]   r_sh;
    logic [LEVEL_W-1:0]   r_dvs;
    logic [LEVEL_W:0]     w_trial;
    logic [LEVEL_W:0]     w_diff;
    logic                 w_ge;

    // The upper dividend half is always below the divisor, so the
    // quotient fits in 32 bits.
    assign w_trial = {r_rem, r_sh[LEVEL_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_dvs};
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (&r_cnt) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.dividend[DIVD_W-1:LEVEL_W];
            r_sh  <= i_req.dividend[LEVEL_W-1:0];
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[LEVEL_W-1:0] : w_trial[LEVEL_W-1:0];
            r_sh  <= {r_sh[LEVEL_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_sh;

endmodule

// ===== rtl/core/ssc_chk.sv =====
// ----------------------------------------------------------------------------
// ssc_chk
// Port-level checks of the compressor top level, attached by bind.
// ----------------------------------------------------------------------------
`include "stereo_sustain_compressor_top_assert.svh"

module ssc_chk #(
    parameter int SAMPLE_WIDTH = 24
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_ready,
    input logic                    o_out_valid,
    input logic                    i_out_ready,
    input logic [SAMPLE_WIDTH-1:0] o_left_out,
    input logic [SAMPLE_WIDTH-1:0] o_right_out
);

    // The block works on one item at a time, so an input transfer closes
    // the input side for at least the next cycle.
    `SSC_ASSERT_ON(a_busy_after_in, (i_in_valid && o_in_ready) |=> !o_in_ready, "ready after input transfer")

    // No result can appear in the cycle right after an input transfer.
    `SSC_ASSERT_ON(a_no_early_out, (i_in_valid && o_in_ready) |=> !$rose(o_out_valid), "result too early")

    // A stalled result holds its value.
    `SSC_ASSERT_ON(a_out_hold, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_left_out) && $stable(o_right_out)), "stalled result changed")

    // Reset empties the block and opens the input side.
    `SSC_ASSERT_RST(a_reset_state, !i_rst_n |=> (!o_out_valid && o_in_ready), "state after reset")

endmodule

bind stereo_sustain_compressor_top ssc_chk #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_ssc_chk (.*);

// ===== tb/tb_stereo_sustain_compressor_top.sv =====
// ----------------------------------------------------------------------------
// Sustain compressor testbench
// Drives stereo sample pairs through the compressor with random bursts and
// output stalls, predicts every compressed pair in a scoreboard class and
// compares them field by field. Registers are changed between idle phases.
// ----------------------------------------------------------------------------
module tb_stereo_sustain_compressor_top;
    import ssc_pkg::*;

    localparam int SW = 24;
    localparam int SAMPLE_COUNT = 550;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef logic signed [SW-1:0] t_sample;

    // Predicts the compressor bit for bit and holds the expected output pairs.
    class comp_scoreboard;
        logic [GAIN_W-1:0]  input_gain;
        logic [COEF_W-1:0]  output_level;
        logic [THR_W-1:0]   base_thr;
        logic [COEF_W-1:0]  comp_ratio;
        logic [COEF_W-1:0]  peak_release;
        logic [COEF_W-1:0]  env_alpha;
        logic [HOLD_W-1:0]  hold_samples;
        logic [63:0]        peak_level;
        logic [63:0]        envelope;
        logic [63:0]        dyn_thr;
        logic [63:0]        hold_timer;
        t_sample            want_left[$];
        t_sample            want_right[$];
        int                 failures;

        function new();
            input_gain   = RST_INPUT_GAIN;
            output_level = RST_OUTPUT_LEVEL;
            base_thr     = RST_BASE_THR;
            comp_ratio   = RST_COMP_RATIO;
            peak_release = RST_PEAK_RELEASE;
            env_alpha    = RST_ENV_ALPHA;
            hold_samples = RST_HOLD_SAMPLES;
            peak_level   = 0;
            envelope     = 0;
            dyn_thr      = RST_DYN_THR;
            hold_timer   = 0;
            failures     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_INPUT_GAIN:   input_gain   = data[GAIN_W-1:0];
                CFG_OUTPUT_LEVEL: output_level = data[COEF_W-1:0];
                CFG_BASE_THR:     base_thr     = data[THR_W-1:0];
                CFG_COMP_RATIO:   comp_ratio   = data[COEF_W-1:0];
                CFG_PEAK_RELEASE: peak_release = data[COEF_W-1:0];
                CFG_ENV_ALPHA:    env_alpha    = data[COEF_W-1:0];
                CFG_HOLD_SAMPLES: hold_samples = data[HOLD_W-1:0];
                default: ;
            endcase
        endfunction

        function t_sample clip(longint v);
            if (v > 8388607) return t_sample'(8388607);
            if (v < -8388608) return t_sample'(-8388608);
            return t_sample'(v);
        endfunction

        // Runs one compressor step on an accepted pair and queues its output.
        function void note_input(t_sample l, t_sample r);
            longint gl, gr, mean, tl, tr;
            logic [63:0] mag, a, thr, gain, lvl, nt;
            gl = (longint'(l) * longint'({1'b0, input_gain})) >>> 16;
            gr = (longint'(r) * longint'({1'b0, input_gain})) >>> 16;
            mean = (gl + gr) >>> 1;
            mag = mean < 0 ? -mean : mean;
            if (mag > 64'hFFFF_FFFF) mag = 64'hFFFF_FFFF;
            if (mag > peak_level) begin
                peak_level = mag;
                hold_timer = 0;
            end
            if (hold_timer > hold_samples) begin
                peak_level = (peak_level * peak_release) >> 16;
                if (peak_level > 64'hFFFF_FFFF) peak_level = 64'hFFFF_FFFF;
            end else begin
                hold_timer = (hold_timer + 1) & 64'h1FFFF;
            end
            a = env_alpha > UNITY ? 64'(UNITY) : 64'(env_alpha);
            envelope = ((64'(UNITY) - a) * envelope + a * peak_level) >> 16;
            thr = dyn_thr;
            if (envelope > thr) begin
                lvl = thr + (thr * (envelope - thr)) / envelope;
                nt = 64'(base_thr) + ((64'(comp_ratio) * (lvl - thr)) >> 16);
                gain = (lvl << 16) / envelope;
                thr = nt > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : nt;
            end else begin
                gain = 64'(UNITY);
            end
            if (envelope < thr) thr = envelope;
            if (thr < base_thr) thr = base_thr;
            dyn_thr = thr;
            tl = (gl * longint'(gain)) >>> 16;
            tr = (gr * longint'(gain)) >>> 16;
            want_left.push_back(clip((tl * longint'(output_level)) >>> 16));
            want_right.push_back(clip((tr * longint'(output_level)) >>> 16));
        endfunction

        function void check_output(t_sample l, t_sample r);
            t_sample el, er;
            if (want_left.size() == 0) begin
                $error("output pair with none expected: left %0d right %0d", l, r);
                failures++;
                return;
            end
            el = want_left.pop_front();
            er = want_right.pop_front();
            if (l !== el) begin
                $error("left_out mismatch: expected %0d actual %0d", el, l);
                failures++;
            end
            if (r !== er) begin
                $error("right_out mismatch: expected %0d actual %0d", er, r);
                failures++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_sample               i_left_in;
    t_sample               i_right_in;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_sample               o_left_out;
    t_sample               o_right_out;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    comp_scoreboard        sb;
    longint                cycle_count;
    bit                    stall_enable;

    stereo_sustain_compressor_top #(.SAMPLE_WIDTH(SW)) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_left_in   (i_left_in),
        .i_right_in  (i_right_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_left_out  (o_left_out),
        .o_right_out (o_right_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The receiver stalls on its own pattern: random-length runs of ready or
    // not ready, with stalls switched off entirely in one of the random phases.
    initial begin
        int run_len;
        bit level;
        i_out_ready = 1'b0;
        level = 1'b1;
        run_len = 0;
        forever begin
            @(posedge i_clk);
            if (run_len == 0) begin
                level = !level;
                run_len = level ? $urandom_range(1, 20) : $urandom_range(1, 12);
            end
            run_len--;
            i_out_ready <= level || !stall_enable;
        end
    end

    // Every output transfer is checked the moment it happens.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_output(o_left_out, o_right_out);
        end
    end

    // The watchdog ends a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Sends one pair and waits for its transfer. Valid stays high across
    // back-to-back transfers because it is only lowered by send_gap.
    task automatic send_pair(t_sample l, t_sample r);
        i_in_valid <= 1'b1;
        i_left_in  <= l;
        i_right_in <= r;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_input(l, r);
    endtask

    task automatic send_gap(int cycles);
        if (cycles > 0) begin
            i_in_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Waits until every expected pair has come out, then lets the block settle.
    task automatic drain();
        send_gap(1);
        while (sb.want_left.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    // Random sample: half the time any value, otherwise full scale or tiny.
    function automatic t_sample rand_sample();
        case ($urandom_range(0, 5))
            0: return t_sample'(8388607);
            1: return t_sample'(-8388608);
            2: return t_sample'($signed($urandom_range(0, 255)) - 128);
            default: return t_sample'($urandom());
        endcase
    endfunction

    task automatic random_burst_phase(int count);
        int left;
        left = count;
        while (left > 0) begin
            int burst;
            burst = $urandom_range(1, 12);
            while (burst > 0 && left > 0) begin
                send_pair(rand_sample(), rand_sample());
                burst--;
                left--;
            end
            send_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 60));
        end
    endtask

    // Random register setting; several registers are pushed to their extremes now
    // and then so the alpha and release above unity cases are reached.
    task automatic random_config();
        write_reg(CFG_INPUT_GAIN, $urandom_range(0, 3) == 0 ?
                  CFG_DATA_W'($urandom_range(0, 24'hFFFFFF)) :
                  CFG_DATA_W'($urandom_range(20000, 400000)));
        write_reg(CFG_OUTPUT_LEVEL, CFG_DATA_W'($urandom_range(0, 65536)));
        write_reg(CFG_BASE_THR, $urandom_range(0, 3) == 0 ?
                  CFG_DATA_W'($urandom() & 32'h7FFF_FFFF) :
                  CFG_DATA_W'($urandom_range(0, 8000000)));
        write_reg(CFG_COMP_RATIO, CFG_DATA_W'($urandom_range(0, 131071)));
        write_reg(CFG_PEAK_RELEASE, CFG_DATA_W'($urandom_range(0, 131071)));
        write_reg(CFG_ENV_ALPHA, CFG_DATA_W'($urandom_range(0, 131071)));
        write_reg(CFG_HOLD_SAMPLES, $urandom_range(0, 3) == 0 ?
                  CFG_DATA_W'($urandom_range(0, 65535)) :
                  CFG_DATA_W'($urandom_range(0, 8)));
    endtask

    initial begin
        sb = new();
        cycle_count = 0;
        stall_enable = 1'b1;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_left_in  = '0;
        i_right_in = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at reset settings: full-scale, zero and mixed-sign
        // pairs drive the threshold into compression.
        send_pair(t_sample'(8388607), t_sample'(8388607));
        send_pair(t_sample'(-8388608), t_sample'(-8388608));
        send_pair(t_sample'(8388607), t_sample'(-8388608));
        send_pair('0, '0);
        send_pair(t_sample'(-1), t_sample'(1));
        send_pair(t_sample'(1000000), t_sample'(-3));
        drain();

        // Alpha and release above unity, zero hold: the peak grows and
        // saturates, and the threshold can overflow with a large base.
        write_reg(CFG_INPUT_GAIN, CFG_DATA_W'(24'hFFFFFF));
        write_reg(CFG_OUTPUT_LEVEL, CFG_DATA_W'(65536));
        write_reg(CFG_BASE_THR, CFG_DATA_W'(31'h7FFFFFFF));
        write_reg(CFG_COMP_RATIO, CFG_DATA_W'(131071));
        write_reg(CFG_PEAK_RELEASE, CFG_DATA_W'(131071));
        write_reg(CFG_ENV_ALPHA, CFG_DATA_W'(131071));
        write_reg(CFG_HOLD_SAMPLES, CFG_DATA_W'(0));
        repeat (6) send_pair(t_sample'(8388607), t_sample'(8388607));
        send_pair(t_sample'(-8388608), t_sample'(8388607));
        drain();

        // Small base and zero gain terms, then a base change between items
        // that the clamp applies on the next step.
        write_reg(CFG_INPUT_GAIN, CFG_DATA_W'(0));
        write_reg(CFG_OUTPUT_LEVEL, CFG_DATA_W'(0));
        write_reg(CFG_BASE_THR, CFG_DATA_W'(0));
        write_reg(CFG_COMP_RATIO, CFG_DATA_W'(0));
        write_reg(CFG_PEAK_RELEASE, CFG_DATA_W'(0));
        write_reg(CFG_ENV_ALPHA, CFG_DATA_W'(0));
        write_reg(CFG_HOLD_SAMPLES, CFG_DATA_W'(16'hFFFF));
        send_pair(t_sample'(8388607), t_sample'(-8388608));
        drain();
        write_reg(CFG_INPUT_GAIN, CFG_DATA_W'(65536));
        write_reg(CFG_OUTPUT_LEVEL, CFG_DATA_W'(65536));
        write_reg(CFG_ENV_ALPHA, CFG_DATA_W'(32768));
        repeat (4) send_pair(t_sample'(4000000), t_sample'(-2000000));
        drain();
        write_reg(CFG_BASE_THR, CFG_DATA_W'(1000));
        write_reg(CFG_COMP_RATIO, CFG_DATA_W'(65536));
        write_reg(CFG_PEAK_RELEASE, CFG_DATA_W'(60000));
        write_reg(CFG_HOLD_SAMPLES, CFG_DATA_W'(2));
        repeat (6) send_pair(t_sample'(3000000), t_sample'(3000000));
        drain();

        // Random phases, each with its own register setting. One phase runs
        // with the receiver always ready.
        for (int phase = 0; phase < 10; phase++) begin
            stall_enable = (phase != 3);
            random_config();
            random_burst_phase(53);
            drain();
        end

        if (sb.want_left.size() != 0) begin
            $error("%0d expected output pairs never arrived", sb.want_left.size());
            sb.failures++;
        end
        if (sb.failures == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
